### src/ping_pong_tx_buffer_controller_macros.svh
// Assertion helpers for the ping-pong tx buffer controller.
// Both sample on clk and are off while rst_n is low.
`ifndef PING_PONG_TX_BUFFER_CONTROLLER_MACROS_SVH
`define PING_PONG_TX_BUFFER_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PPTXB_ASSERT_IMP(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("pptxb same-cycle check failed");

// next-cycle implication
`define PPTXB_ASSERT_NXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("pptxb next-cycle check failed");

`endif

### src/pptxb_pkg.sv
package pptxb_pkg;

  localparam int BUFFER_DEPTH_DEF = 128;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_FLUSH = 2'd1,
    OP_DONE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_FILLING = 2'd1,
    ST_FILLED  = 2'd2
  } buf_status_t;

endpackage

### src/pptxb_ram.sv
module pptxb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ping_pong_tx_buffer_controller.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | operation, data_byte, read_buffer, read_index
// out     | output    | out_valid / out_ready  | accepted, tx_launch, tx_buffer, tx_length,
//         |           |                        | stop_tx, read_value
//
// One beat per cycle sustained while the output is not stalled. A result passes
// stage 1, beside the byte store's registered read port (one stage), and then the
// output register. Control state (mode, counts, status) resets synchronously on
// rst_n low; the byte store is not cleared and needs no sweep. A stalled output
// holds the pending result and the store's read data until the output drains.
`include "ping_pong_tx_buffer_controller_macros.svh"

module ping_pong_tx_buffer_controller
  import pptxb_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_read_buffer,
  input  logic [6:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic       out_tx_launch,
  output logic       out_tx_buffer,
  output logic [7:0] out_tx_length,
  output logic       out_stop_tx,
  output logic [7:0] out_read_value
);

  localparam int STORE_DEPTH = 2 * BUFFER_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

  // link mode: buffer named by cur_r is the one sent / last sent,
  // the other one fills
  logic cur_r, cur_nxt;
  logic sending_r, sending_nxt;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  buf_status_t   st_r [2];
  buf_status_t   st_nxt [2];

  // stage 1: result fields waiting on the store read
  logic       s1_valid_r;
  logic       s1_acc_r, s1_start_r, s1_txb_r, s1_stop_r, s1_rd_r;
  logic [7:0] s1_len_r;

  logic       out_valid_r;
  logic       out_acc_r, out_start_r, out_txb_r, out_stop_r;
  logic [7:0] out_len_r, out_rval_r;

  logic in_fire, s1_adv;
  op_t  op;
  logic cur, oth;

  // combinational result of the accepted beat
  logic        acc_c, start_c, txb_c, stop_c, rd_c;
  logic [31:0] len_c;

  // store ports
  logic          we_c, re_c;
  logic [AW-1:0] waddr_c, raddr_c;
  logic [7:0]    rdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(in_operation);
  assign cur      = cur_r;
  assign oth      = ~cur_r;

  always_comb begin
    cur_nxt     = cur_r;
    sending_nxt = sending_r;
    cnt_nxt     = cnt_r;
    st_nxt      = st_r;
    acc_c       = 1'b1;
    start_c     = 1'b0;
    txb_c       = 1'b0;
    len_c       = '0;
    stop_c      = 1'b0;
    rd_c        = 1'b0;
    we_c        = 1'b0;
    re_c        = 1'b0;
    waddr_c     = '0;
    raddr_c     = '0;
    if (in_fire) begin
      case (op)
        OP_PUT: begin
          if (cnt_r[oth] != FULL_CNT) begin
            we_c         = 1'b1;
            waddr_c      = AW'(32'(oth ? BUFFER_DEPTH : 0) + 32'(cnt_r[oth]));
            cnt_nxt[oth] = cnt_r[oth] + 1'b1;
            st_nxt[oth]  = ST_FILLING;
          end else if (sending_r) begin
            acc_c = 1'b0;  // both busy: producer retries
          end else begin
            // full buffer goes out, byte lands in the freed one
            start_c     = 1'b1;
            txb_c       = oth;
            len_c       = 32'(cnt_r[oth]);
            st_nxt[oth] = ST_FILLED;
            cur_nxt     = oth;
            sending_nxt = 1'b1;
            if (cnt_r[cur] != FULL_CNT) begin
              we_c         = 1'b1;
              waddr_c      = AW'(32'(cur ? BUFFER_DEPTH : 0) + 32'(cnt_r[cur]));
              cnt_nxt[cur] = cnt_r[cur] + 1'b1;
              st_nxt[cur]  = ST_FILLING;
            end
          end
        end
        OP_FLUSH: begin
          if (!sending_r) begin
            start_c     = 1'b1;
            txb_c       = oth;
            len_c       = 32'(cnt_r[oth]);
            cur_nxt     = oth;
            sending_nxt = 1'b1;
          end
          st_nxt[oth] = ST_FILLED;
        end
        OP_DONE: begin
          if (sending_r) begin
            st_nxt[cur]  = ST_EMPTY;
            cnt_nxt[cur] = '0;
            if (st_r[oth] == ST_FILLED) begin
              start_c = 1'b1;
              txb_c   = oth;
              len_c   = 32'(cnt_r[oth]);
              cur_nxt = oth;
            end else begin
              sending_nxt = 1'b0;
              stop_c      = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (32'(in_read_index) < 32'(BUFFER_DEPTH)) begin
            rd_c    = 1'b1;
            re_c    = 1'b1;
            raddr_c = AW'(32'(in_read_buffer ? BUFFER_DEPTH : 0) + 32'(in_read_index));
          end
        end
        default: begin
        end
      endcase
    end
  end

  pptxb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we_c),
    .waddr(waddr_c),
    .wdata(in_data_byte),
    .re   (re_c),
    .raddr(raddr_c),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= 1'b0;
      sending_r   <= 1'b0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      st_r[0]     <= ST_EMPTY;
      st_r[1]     <= ST_EMPTY;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r     <= cur_nxt;
      sending_r <= sending_nxt;
      cnt_r     <= cnt_nxt;
      st_r      <= st_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r   <= acc_c;
      s1_start_r <= start_c;
      s1_txb_r   <= txb_c;
      s1_len_r   <= len_c[7:0];
      s1_stop_r  <= stop_c;
      s1_rd_r    <= rd_c;
    end
    if (s1_adv) begin
      out_acc_r   <= s1_acc_r;
      out_start_r <= s1_start_r;
      out_txb_r   <= s1_txb_r;
      out_len_r   <= s1_len_r;
      out_stop_r  <= s1_stop_r;
      out_rval_r  <= s1_rd_r ? rdata : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_tx_launch  = out_start_r;
  assign out_tx_buffer  = out_txb_r;
  assign out_tx_length  = out_len_r;
  assign out_stop_tx    = out_stop_r;
  assign out_read_value = out_rval_r;

  // the buffer on the wire is always marked filled
  `PPTXB_ASSERT_IMP(a_sending_filled, sending_r, st_r[cur_r] == ST_FILLED)
  // counts never pass the buffer size
  `PPTXB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r[0] <= FULL_CNT && cnt_r[1] <= FULL_CNT)
  // a result never starts and stops at once
  `PPTXB_ASSERT_IMP(a_start_stop_excl, out_valid_r, !(out_start_r && out_stop_r))
  // done with nothing queued leaves the link idle
  `PPTXB_ASSERT_NXT(a_done_idle, stop_c, !sending_r)

endmodule
